// ----- hdl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the printf conversion spec parser.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int unsigned MaxSpecLenDefault = 255;

	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChQuote = 8'h27;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChHash  = 8'h23;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChLowH  = 8'h68;
	localparam logic [7:0] ChLowL  = 8'h6C;
	localparam logic [7:0] ChLowJ  = 8'h6A;
	localparam logic [7:0] ChUpL   = 8'h4C;
	localparam logic [7:0] ChUpD   = 8'h44;
	localparam logic [7:0] ChLowW  = 8'h77;

	localparam int unsigned FlagLeft  = 0;
	localparam int unsigned FlagPlus  = 1;
	localparam int unsigned FlagThou  = 2;
	localparam int unsigned FlagZero  = 3;
	localparam int unsigned FlagAlt   = 4;
	localparam int unsigned FlagSpace = 5;

	localparam logic [31:0] SatMax = 32'h7FFF_FFFF;
	localparam logic [31:0] NotGiven = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		LM_NONE = 4'd0,
		LM_H    = 4'd1,
		LM_L    = 4'd2,
		LM_J    = 4'd3,
		LM_LL   = 4'd4,
		LM_D    = 4'd5,
		LM_W    = 4'd6,
		LM_HH   = 4'd7,
		LM_JJ   = 4'd8
	} len_mod_t;

	typedef enum logic [2:0] {
		PH_FLAGS  = 3'd0,
		PH_WDIG   = 3'd1,
		PH_AFTERW = 3'd2,
		PH_PSTART = 3'd3,
		PH_PDIG   = 3'd4,
		PH_MODS   = 3'd5
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [5:0]  flags;
		logic [31:0] width;
		logic [31:0] prec;
		len_mod_t    mod;
		logic [1:0]  half_cnt;
		logic [1:0]  long_cnt;
		logic [1:0]  imax_cnt;
	} spec_state_t;

	typedef struct packed {
		logic [3:0]  length_mod;
		logic [31:0] precision;
		logic [31:0] field_width;
		logic [5:0]  flags;
		logic [7:0]  skip_len;
		logic [7:0]  code;
		logic        status;
	} spec_result_t;

	localparam spec_state_t SpecClear = '{
		phase: PH_FLAGS, flags: 6'd0, width: NotGiven, prec: NotGiven,
		mod: LM_NONE, half_cnt: 2'd0, long_cnt: 2'd0, imax_cnt: 2'd0
	};

endpackage

// ----- hdl/pfs_digit.sv -----
// ----------------------------------------------------------------------------
// pfs_digit
// Appends one decimal digit to a value, saturating at the largest int.
// ----------------------------------------------------------------------------
module pfs_digit (
	input  logic [31:0] base,
	input  logic [7:0]  ch,
	output logic [31:0] sum
);
	import pfs_pkg::*;

	logic [3:0]  digit;
	logic [31:0] limit;
	logic [31:0] times_ten;

	assign digit     = ch[3:0] - ChZero[3:0];
	assign limit     = (digit > 4'd7) ? 32'd214748363 : 32'd214748364;
	assign times_ten = {base[28:0], 3'b000} + {base[30:0], 1'b0};
	assign sum       = (base > limit) ? SatMax : (times_ten + {28'd0, digit});

endmodule

// ----- hdl/pfs_step.sv -----
// ----------------------------------------------------------------------------
// pfs_step
// Next-state and result logic for one character of a conversion spec.
// ----------------------------------------------------------------------------
module pfs_step (
	input  pfs_pkg::spec_state_t  cur,
	input  logic [7:0]            ch,
	input  logic [31:0]           star_value,
	input  logic                  last,
	input  logic [7:0]            skip_len,
	output pfs_pkg::spec_state_t  nxt,
	output logic                  emit,
	output pfs_pkg::spec_result_t res
);
	import pfs_pkg::*;

	logic [31:0] wbase;
	logic [31:0] pbase;
	logic [31:0] wsum;
	logic [31:0] psum;
	logic        is_dig;

	assign is_dig = (ch >= ChZero) && (ch <= ChNine);
	assign wbase  = (cur.phase == PH_FLAGS) ? 32'd0 : cur.width;
	assign pbase  = (cur.phase == PH_PSTART) ? 32'd0 : cur.prec;

	pfs_digit u_wdig (.base(wbase), .ch(ch), .sum(wsum));
	pfs_digit u_pdig (.base(pbase), .ch(ch), .sum(psum));

	function automatic logic [1:0] bump(input logic [1:0] n);
		return (n == 2'd3) ? 2'd3 : n + 2'd1;
	endfunction

	always_comb begin
		spec_state_t s;
		phase_t      ph;
		logic        taken;
		logic [5:0]  fl;
		len_mod_t    lm;

		s     = cur;
		ph    = cur.phase;
		taken = 1'b0;
		fl    = 6'd0;
		case (ch)
			ChMinus: fl[FlagLeft]  = 1'b1;
			ChPlus:  fl[FlagPlus]  = 1'b1;
			ChQuote: fl[FlagThou]  = 1'b1;
			ChZero:  fl[FlagZero]  = 1'b1;
			ChHash:  fl[FlagAlt]   = 1'b1;
			ChSpace: fl[FlagSpace] = 1'b1;
			default: fl = 6'd0;
		endcase

		if (ph == PH_FLAGS) begin
			if (fl != 6'd0) begin
				s.flags = s.flags | fl;
				taken = 1'b1;
			end else if (ch == ChStar) begin
				if (star_value[31]) begin
					s.width = (star_value == 32'h8000_0000) ? SatMax : (~star_value + 32'd1);
					s.flags[FlagLeft] = ~s.flags[FlagLeft];
				end else begin
					s.width = star_value;
				end
				ph = PH_AFTERW;
				taken = 1'b1;
			end else if (is_dig) begin
				s.width = wsum;
				ph = PH_WDIG;
				taken = 1'b1;
			end else begin
				ph = PH_AFTERW;
			end
		end
		if (!taken && ph == PH_WDIG) begin
			if (is_dig) begin
				s.width = wsum;
				taken = 1'b1;
			end else begin
				ph = PH_AFTERW;
			end
		end
		if (!taken && ph == PH_AFTERW) begin
			if (ch == ChDot) begin
				s.prec = 32'd0;
				ph = PH_PSTART;
				taken = 1'b1;
			end else begin
				ph = PH_MODS;
			end
		end
		if (!taken && ph == PH_PSTART) begin
			if (ch == ChStar) begin
				s.prec = star_value;
				ph = PH_MODS;
				taken = 1'b1;
			end else if (is_dig) begin
				s.prec = psum;
				ph = PH_PDIG;
				taken = 1'b1;
			end else begin
				ph = PH_MODS;
			end
		end
		if (!taken && ph == PH_PDIG) begin
			if (is_dig) begin
				s.prec = psum;
				taken = 1'b1;
			end else begin
				ph = PH_MODS;
			end
		end
		if (!taken) begin
			ph = PH_MODS;
			taken = 1'b1;
			case (ch)
				ChLowH: begin
					s.mod = LM_H;
					s.half_cnt = bump(s.half_cnt);
				end
				ChLowL: begin
					s.mod = LM_L;
					s.long_cnt = bump(s.long_cnt);
				end
				ChLowJ: begin
					s.mod = LM_J;
					s.imax_cnt = bump(s.imax_cnt);
				end
				ChUpL:   s.mod = LM_LL;
				ChUpD:   s.mod = LM_D;
				ChLowW:  s.mod = LM_W;
				default: taken = 1'b0;
			endcase
		end
		s.phase = ph;

		lm = s.mod;
		if (s.half_cnt > 2'd1) lm = LM_HH;
		if (s.long_cnt > 2'd1) lm = LM_LL;
		if (s.imax_cnt > 2'd1) lm = LM_JJ;

		res = '0;
		if (taken) begin
			emit = last;
			nxt  = last ? SpecClear : s;
			res.status = 1'b1;
		end else begin
			emit = 1'b1;
			nxt  = SpecClear;
			res.status      = 1'b0;
			res.code        = ch;
			res.skip_len    = skip_len;
			res.flags       = s.flags;
			res.field_width = s.width;
			res.precision   = s.prec;
			res.length_mod  = lm;
		end
	end

endmodule

// ----- hdl/printf_format_spec_parser.sv -----
// ----------------------------------------------------------------------------
// printf_format_spec_parser
// Parses a printf conversion spec from the characters after a percent sign.
// ----------------------------------------------------------------------------
// Each request carries one character; the parser emits one result when the
// conversion code arrives, or an invalid result (all fields zero, tuser set)
// when tlast marks the end of input first. A character is taken every cycle
// unless the output is stalled: the spec state is updated by one pass of logic
// from the input register, and the result is registered in the output register.
module printf_format_spec_parser #(
	parameter int unsigned MAX_SPEC_LEN = pfs_pkg::MaxSpecLenDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // ch[7:0], star_value[39:8]
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // code, skip_len, left, plus, thousands,
	                                   // zero_fill, alternate, space, field_width,
	                                   // precision, length_mod, zero pad
	output logic        m_axis_tuser   // status
);
	import pfs_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_SPEC_LEN + 1);

	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic [31:0]   star_s1;
	logic          last_s1;
	spec_state_t   state_q;
	logic [CntW-1:0] consumed_q;
	logic [CntW-1:0] consumed_inc;
	logic [7:0]    skip_len;
	spec_state_t   state_nxt;
	logic          emit;
	spec_result_t  res;
	spec_result_t  res_q;
	logic          advance;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	assign consumed_inc = (consumed_q < CntW'(MAX_SPEC_LEN)) ? consumed_q + 1'b1 : consumed_q;
	assign skip_len     = (consumed_inc > CntW'(255)) ? 8'd255 : 8'(consumed_inc);

	pfs_step u_step (
		.cur(state_q), .ch(ch_s1), .star_value(star_s1), .last(last_s1),
		.skip_len(skip_len), .nxt(state_nxt), .emit(emit), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			state_q       <= SpecClear;
			consumed_q    <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (valid_s1 && advance) begin
				state_q       <= state_nxt;
				consumed_q    <= emit ? '0 : consumed_inc;
				m_axis_tvalid <= emit;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata[7:0];
			star_s1 <= s_axis_tdata[39:8];
			last_s1 <= s_axis_tlast;
		end
		if (valid_s1 && advance && emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {6'd0, res_q.length_mod, res_q.precision, res_q.field_width,
		res_q.flags, res_q.skip_len, res_q.code};
	assign m_axis_tuser = res_q.status;

`ifndef ASSERT_OFF
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 96'd0)
		else $error("invalid result carries nonzero fields");
	a_ok_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] != 8'd0)
		else $error("ok result with zero skip length");
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !state_q.width[31] || state_q.width == NotGiven)
		else $error("field width below minus one");
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && emit |=> consumed_q == '0 && state_q.phase == PH_FLAGS)
		else $error("spec state not cleared after result");
`endif

endmodule

// ----- tb/printf_format_spec_parser_test.sv -----
// ----------------------------------------------------------------------------
// printf_format_spec_parser_test
// Streams conversion spec characters into the parser and checks every result.
// ----------------------------------------------------------------------------
// The bench feeds characters through the request stream and predicts each spec
// result with its own parser model. It checks every result field by field. The
// directed tests cover flags, star widths, the zero flag against a width digit,
// star precision, modifier promotion, misplaced characters and early end. Then
// come long specs, a run with no idling and a long output stall. A large run of
// random specs follows, mixed with broken specs and noise.
module printf_format_spec_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfs_pkg::*;

	localparam int QuietLimit = 3000;
	localparam int HoldOffCycles = 400;
	localparam int DrainCycles = 10;
	localparam int RandomChars = 300;

	typedef struct packed {
		logic [7:0]  code;
		logic [7:0]  skip_len;
		logic        status;
		logic [5:0]  flags;
		logic [31:0] field_width;
		logic [31:0] precision;
		len_mod_t    length_mod;
	} spec_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	phase_t      cur_phase;
	logic [5:0]  cur_flags;
	logic [31:0] cur_width;
	logic [31:0] cur_prec;
	len_mod_t    cur_mod;
	logic [1:0]  n_half;
	logic [1:0]  n_long;
	logic [1:0]  n_imax;
	int          n_chars;

	spec_report_t expected_specs[$];
	spec_report_t want;
	int          mismatches = 0;
	int          accepted_chars = 0;
	int          quiet_cycles = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	bit          steady = 1'b0;
	string       conv_codes = "diouxXfFeEgGaAcspn%";

	printf_format_spec_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_digit(input logic [7:0] c);
		return c >= ChZero && c <= ChNine;
	endfunction

	function automatic logic [31:0] add_digit(input logic [31:0] v, input logic [7:0] c);
		logic [31:0] d;
		d = {24'd0, c - ChZero};
		if (v > (SatMax - d) / 10) begin
			return SatMax;
		end
		return v * 10 + d;
	endfunction

	function automatic logic [1:0] count_up(input logic [1:0] n);
		return (n == 2'd3) ? 2'd3 : n + 2'd1;
	endfunction

	function automatic void clear_spec();
		cur_phase = PH_FLAGS;
		cur_flags = '0;
		cur_width = NotGiven;
		cur_prec = NotGiven;
		cur_mod = LM_NONE;
		n_half = '0;
		n_long = '0;
		n_imax = '0;
		n_chars = 0;
	endfunction

	// Returns 1 when the character is absorbed by a phase of the spec.
	function automatic bit take_spec_char(input logic [7:0] c, input logic [31:0] sv);
		logic [5:0]  mask;
		logic [31:0] mag;
		if (cur_phase == PH_FLAGS) begin
			mask = '0;
			case (c)
				ChMinus: mask[FlagLeft] = 1'b1;
				ChPlus:  mask[FlagPlus] = 1'b1;
				ChQuote: mask[FlagThou] = 1'b1;
				ChZero:  mask[FlagZero] = 1'b1;
				ChHash:  mask[FlagAlt] = 1'b1;
				ChSpace: mask[FlagSpace] = 1'b1;
				default: ;
			endcase
			if (mask != '0) begin
				cur_flags = cur_flags | mask;
				return 1'b1;
			end
			if (c == ChStar) begin
				if (sv[31]) begin
					mag = -sv;
					cur_width = (mag > SatMax) ? SatMax : mag;
					cur_flags[FlagLeft] = ~cur_flags[FlagLeft];
				end else begin
					cur_width = sv;
				end
				cur_phase = PH_AFTERW;
				return 1'b1;
			end
			if (is_digit(c)) begin
				cur_width = add_digit('0, c);
				cur_phase = PH_WDIG;
				return 1'b1;
			end
			cur_phase = PH_AFTERW;
		end
		if (cur_phase == PH_WDIG) begin
			if (is_digit(c)) begin
				cur_width = add_digit(cur_width, c);
				return 1'b1;
			end
			cur_phase = PH_AFTERW;
		end
		if (cur_phase == PH_AFTERW) begin
			if (c == ChDot) begin
				cur_prec = '0;
				cur_phase = PH_PSTART;
				return 1'b1;
			end
			cur_phase = PH_MODS;
		end
		if (cur_phase == PH_PSTART) begin
			if (c == ChStar) begin
				cur_prec = sv;
				cur_phase = PH_MODS;
				return 1'b1;
			end
			if (is_digit(c)) begin
				cur_prec = add_digit('0, c);
				cur_phase = PH_PDIG;
				return 1'b1;
			end
			cur_phase = PH_MODS;
		end
		if (cur_phase == PH_PDIG) begin
			if (is_digit(c)) begin
				cur_prec = add_digit(cur_prec, c);
				return 1'b1;
			end
		end
		cur_phase = PH_MODS;
		case (c)
			ChLowH: begin
				cur_mod = LM_H;
				n_half = count_up(n_half);
			end
			ChLowL: begin
				cur_mod = LM_L;
				n_long = count_up(n_long);
			end
			ChLowJ: begin
				cur_mod = LM_J;
				n_imax = count_up(n_imax);
			end
			ChUpL:  cur_mod = LM_LL;
			ChUpD:  cur_mod = LM_D;
			ChLowW: cur_mod = LM_W;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	task automatic predict_spec_char(input logic [7:0] c, input logic [31:0] sv, input bit lst);
		spec_report_t r;
		r = '0;
		if (n_chars < MaxSpecLenDefault) begin
			n_chars++;
		end
		if (take_spec_char(c, sv)) begin
			if (lst) begin
				r.status = 1'b1;
				expected_specs.push_back(r);
				clear_spec();
			end
			return;
		end
		r.code = c;
		r.skip_len = (n_chars > 255) ? 8'd255 : 8'(n_chars);
		r.flags = cur_flags;
		r.field_width = cur_width;
		r.precision = cur_prec;
		r.length_mod = cur_mod;
		if (n_half > 2'd1) begin
			r.length_mod = LM_HH;
		end
		if (n_long > 2'd1) begin
			r.length_mod = LM_LL;
		end
		if (n_imax > 2'd1) begin
			r.length_mod = LM_JJ;
		end
		expected_specs.push_back(r);
		clear_spec();
	endtask

	function automatic logic [31:0] pick_star();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return SatMax;
			2: return NotGiven;
			3: return '0;
			4: return $urandom_range(100);
			5: return -$urandom_range(100);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] pick_flag_char();
		case ($urandom_range(5))
			0: return ChMinus;
			1: return ChPlus;
			2: return ChQuote;
			3: return ChZero;
			4: return ChHash;
			default: return ChSpace;
		endcase
	endfunction

	function automatic logic [7:0] pick_mod_char();
		case ($urandom_range(5))
			0: return ChLowH;
			1: return ChLowL;
			2: return ChLowJ;
			3: return ChUpL;
			4: return ChUpD;
			default: return ChLowW;
		endcase
	endfunction

	// Called and returns at a falling edge; the request stays up until accepted.
	task automatic send_char(input logic [7:0] c, input logic [31:0] sv, input bit lst);
		while (!steady && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {sv, c};
		s_axis_tlast <= lst;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_spec_char(c, sv, lst);
		accepted_chars++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic [31:0] sv, input bit last_at_end);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], sv, last_at_end && i == s.len() - 1);
		end
	endtask

	task automatic send_seq(input logic [7:0] seq[$], input bit last_at_end);
		foreach (seq[i]) begin
			send_char(seq[i], pick_star(), last_at_end && i == seq.size() - 1);
		end
	endtask

	task automatic send_random_spec();
		logic [7:0] seq[$];
		int cut;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				send_char(8'($urandom_range(255)), pick_star(), $urandom_range(99) < 15);
			end
			return;
		end
		repeat ($urandom_range(3)) begin
			seq.push_back(pick_flag_char());
		end
		case ($urandom_range(3))
			0: ;
			1: seq.push_back(ChStar);
			default: begin
				seq.push_back(8'(ChZero + $urandom_range(1, 9)));
				repeat ($urandom_range(11)) begin
					seq.push_back(8'(ChZero + $urandom_range(9)));
				end
			end
		endcase
		if ($urandom_range(2) != 0) begin
			seq.push_back(ChDot);
			case ($urandom_range(2))
				0: ;
				1: seq.push_back(ChStar);
				default: begin
					repeat ($urandom_range(1, 11)) begin
						seq.push_back(8'(ChZero + $urandom_range(9)));
					end
				end
			endcase
		end
		repeat ($urandom_range(3)) begin
			seq.push_back(pick_mod_char());
		end
		if ($urandom_range(4) == 0) begin
			seq.push_back(8'($urandom_range(255)));
		end else begin
			seq.push_back(conv_codes[$urandom_range(conv_codes.len() - 1)]);
		end
		if (seq.size() > 1 && $urandom_range(99) < 8) begin
			cut = $urandom_range(seq.size() - 2);
			while (seq.size() > cut + 1) begin
				void'(seq.pop_back());
			end
			send_seq(seq, 1'b1);
		end else begin
			send_seq(seq, $urandom_range(3) == 0);
		end
	endtask

	task automatic test_flags_and_star_width();
		send_text("-+'0# *d", 32'h8000_0000, 1'b0);
		send_text("-*x", 32'hFFFF_FFFB, 1'b0);
	endtask

	task automatic test_zero_flag_against_digit();
		send_text("010d", $urandom(), 1'b0);
	endtask

	task automatic test_star_precision_and_second_dot();
		send_text(".*.", 32'hFFFF_FFF9, 1'b0);
	endtask

	task automatic test_modifier_promotion();
		send_text("hlhx", $urandom(), 1'b0);
		send_text("Dwjjp", $urandom(), 1'b0);
	endtask

	task automatic test_misplaced_chars();
		send_text("*5", 32'd42, 1'b0);
	endtask

	task automatic test_early_end();
		send_text("-1", $urandom(), 1'b1);
		send_text("d", $urandom(), 1'b1);
	endtask

	task automatic test_long_specs();
		logic [7:0] seq[$];
		repeat (270) begin
			seq.push_back(pick_flag_char());
		end
		seq.push_back(ChLowL);
		seq.push_back(ChLowL);
		seq.push_back(8'h64);
		send_seq(seq, 1'b0);
		seq.delete();
		seq.push_back(8'h31);
		repeat (12) begin
			seq.push_back(8'(ChZero + $urandom_range(9)));
		end
		seq.push_back(ChDot);
		seq.push_back(ChStar);
		seq.push_back(8'h66);
		send_seq(seq, 1'b1);
	endtask

	task automatic test_steady_stream();
		int start;
		start = accepted_chars;
		steady = 1'b1;
		while (accepted_chars - start < 150) begin
			send_random_spec();
		end
		steady = 1'b0;
	endtask

	task automatic test_output_stall();
		int start;
		start = accepted_chars;
		hold_request = HoldOffCycles;
		while (accepted_chars - start < 80) begin
			send_random_spec();
		end
	endtask

	task automatic test_random_specs();
		int start;
		start = accepted_chars;
		while (accepted_chars - start < RandomChars) begin
			send_random_spec();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_specs.size() == 0) begin
				$error("result with no request pending: tdata 0x%0h", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_specs.pop_front();
				check_field("code", 32'(want.code), 32'(m_axis_tdata[7:0]));
				check_field("skip_len", 32'(want.skip_len), 32'(m_axis_tdata[15:8]));
				check_field("left_flag", 32'(want.flags[FlagLeft]), 32'(m_axis_tdata[16]));
				check_field("plus_flag", 32'(want.flags[FlagPlus]), 32'(m_axis_tdata[17]));
				check_field("thousands_flag", 32'(want.flags[FlagThou]),
					32'(m_axis_tdata[18]));
				check_field("zero_fill_flag", 32'(want.flags[FlagZero]),
					32'(m_axis_tdata[19]));
				check_field("alternate_flag", 32'(want.flags[FlagAlt]),
					32'(m_axis_tdata[20]));
				check_field("space_flag", 32'(want.flags[FlagSpace]), 32'(m_axis_tdata[21]));
				check_field("field_width", want.field_width, m_axis_tdata[53:22]);
				check_field("precision", want.precision, m_axis_tdata[85:54]);
				check_field("length_mod", 32'(want.length_mod), 32'(m_axis_tdata[89:86]));
				check_field("status", 32'(want.status), 32'(m_axis_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_spec();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_flags_and_star_width();
		test_zero_flag_against_digit();
		test_star_precision_and_second_dot();
		test_modifier_promotion();
		test_misplaced_chars();
		test_early_end();
		test_long_specs();
		test_steady_stream();
		test_output_stall();
		test_random_specs();
		s_axis_tvalid <= 1'b0;
		while (expected_specs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
